/* rtl/half_float_multiplier_macros.svh */
// Assertion macros for the multiplier files.
`ifndef HALF_FLOAT_MULTIPLIER_MACROS_SVH
`define HALF_FLOAT_MULTIPLIER_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define HFM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hfm_pkg.sv */
package hfm_pkg;

    localparam int unsigned HalfWidth = 16;
    localparam int unsigned ExpWidth  = 5;
    localparam int unsigned FracWidth = 10;
    localparam int unsigned SigWidth  = 11;
    localparam int unsigned ProdWidth = 22;
    // Exponent with sign and headroom for rebiasing.
    localparam int unsigned EWidth    = 8;

    localparam logic [HalfWidth-1:0] HpNan  = 16'hFFFF;
    localparam logic [HalfWidth-1:0] HpInf  = 16'h7C00;
    localparam logic [ExpWidth-1:0]  ExpMax = 5'd31;
    localparam logic [EWidth-1:0]    Bias   = 8'd15;

    localparam int unsigned DefaultStages = 4;

    // Special-case classification carried down the pipeline.
    typedef enum logic [1:0] {
        SP_NONE,
        SP_NAN,
        SP_INF,
        SP_ZERO
    } t_special;

endpackage

/* rtl/hfm_round.sv */
// Normalises and rounds the raw significand product and packs the result.
module hfm_round (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_sign,
    input  hfm_pkg::t_special                   i_special,
    input  logic signed [hfm_pkg::EWidth-1:0]   i_exp,
    input  logic [hfm_pkg::ProdWidth-1:0]       i_prod,
    output logic                                o_valid,
    output logic [hfm_pkg::HalfWidth-1:0]       o_product
);

    logic                                 r_valid;
    logic                                 r_sign;
    hfm_pkg::t_special                    r_special;
    logic signed [hfm_pkg::EWidth-1:0]    r_exp;
    logic [hfm_pkg::SigWidth:0]           r_q;
    logic                                 r_inc;
    logic                                 n_inc;
    logic [hfm_pkg::SigWidth:0]           n_q;
    logic signed [hfm_pkg::EWidth-1:0]    n_exp;
    logic [hfm_pkg::SigWidth:0]           q_rnd;
    logic [hfm_pkg::FracWidth-1:0]        frac_out;
    logic signed [hfm_pkg::EWidth-1:0]    exp_out;
    logic                                 r_out_valid;
    logic [hfm_pkg::HalfWidth-1:0]        r_product;
    logic [hfm_pkg::HalfWidth-1:0]        n_product;

    // Normalise by one place and decide the round increment.
    always_comb begin
        logic [10:0] rem;
        logic        half_hit;
        logic        above;
        if (i_prod[hfm_pkg::ProdWidth-1]) begin
            n_q   = {1'b0, i_prod[21:11]};
            n_exp = i_exp + 8'sd1;
            rem   = i_prod[10:0];
        end else begin
            n_q   = {1'b0, i_prod[20:10]};
            n_exp = i_exp;
            rem   = {1'b0, i_prod[9:0]};
        end
        if (i_prod[hfm_pkg::ProdWidth-1]) begin
            half_hit = (rem == 11'h400);
            above    = (rem > 11'h400);
        end else begin
            half_hit = (rem == 11'h200);
            above    = (rem > 11'h200);
        end
        n_inc = above || (half_hit && n_q[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_sign    <= i_sign;
        r_special <= i_special;
        r_exp     <= n_exp;
        r_q       <= n_q;
        r_inc     <= n_inc;
    end

    // Apply the increment, renormalise on carry and pack.
    always_comb begin
        q_rnd    = r_q + {{hfm_pkg::SigWidth{1'b0}}, r_inc};
        frac_out = q_rnd[hfm_pkg::SigWidth] ? q_rnd[10:1] : q_rnd[9:0];
        exp_out  = q_rnd[hfm_pkg::SigWidth] ? r_exp + 8'sd1 : r_exp;
        case (r_special)
            hfm_pkg::SP_NAN:  n_product = hfm_pkg::HpNan;
            hfm_pkg::SP_INF:  n_product = {r_sign, hfm_pkg::HpInf[14:0]};
            hfm_pkg::SP_ZERO: n_product = {r_sign, 15'd0};
            default: begin
                if (exp_out >= 8'sd31) begin
                    n_product = {r_sign, hfm_pkg::HpInf[14:0]};
                end else if (exp_out <= 8'sd0) begin
                    n_product = {r_sign, 15'd0};
                end else begin
                    n_product = {r_sign, exp_out[4:0], frac_out};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid;
        end
        r_product <= n_product;
    end

    assign o_valid   = r_out_valid;
    assign o_product = r_product;

endmodule

/* rtl/half_float_multiplier.sv */
// Half-precision multiplier, round to nearest even, subnormals flushed to
// zero, every NaN given as 0xFFFF. A new operand pair is taken every cycle
// (busy stays low) and its product appears on o_product with o_done high
// for one cycle. The result passes four register stages in order: decode,
// significand multiply, round decision, pack. The receiver cannot hold
// results off, so it must take o_product whenever o_done is high.
`include "half_float_multiplier_macros.svh"

module half_float_multiplier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hfm_pkg::HalfWidth-1:0] i_operand_a,
    input  logic [hfm_pkg::HalfWidth-1:0] i_operand_b,
    output logic                          o_done,
    output logic [hfm_pkg::HalfWidth-1:0] o_product
);

    logic                                a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    hfm_pkg::t_special                   n_special;
    logic                                r_valid1, r_valid2;
    logic                                r_sign1, r_sign2;
    hfm_pkg::t_special                   r_special1, r_special2;
    logic signed [hfm_pkg::EWidth-1:0]   r_exp1, r_exp2;
    logic [hfm_pkg::SigWidth-1:0]        r_sig_a, r_sig_b;
    logic [hfm_pkg::ProdWidth-1:0]       r_prod;

    assign busy = 1'b0;

    // Classify the operands.
    always_comb begin
        a_nan  = (i_operand_a[14:10] == hfm_pkg::ExpMax) && (i_operand_a[9:0] != 10'd0);
        b_nan  = (i_operand_b[14:10] == hfm_pkg::ExpMax) && (i_operand_b[9:0] != 10'd0);
        a_inf  = (i_operand_a[14:10] == hfm_pkg::ExpMax) && (i_operand_a[9:0] == 10'd0);
        b_inf  = (i_operand_b[14:10] == hfm_pkg::ExpMax) && (i_operand_b[9:0] == 10'd0);
        a_zero = (i_operand_a[14:10] == 5'd0);
        b_zero = (i_operand_b[14:10] == 5'd0);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            n_special = hfm_pkg::SP_NAN;
        end else if (a_inf || b_inf) begin
            n_special = hfm_pkg::SP_INF;
        end else if (a_zero || b_zero) begin
            n_special = hfm_pkg::SP_ZERO;
        end else begin
            n_special = hfm_pkg::SP_NONE;
        end
    end

    // Stage one: register decoded operands and the rebiased exponent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else begin
            r_valid1 <= start && !busy;
        end
        r_sign1    <= i_operand_a[15] ^ i_operand_b[15];
        r_special1 <= n_special;
        r_exp1     <= $signed({3'd0, i_operand_a[14:10]}) + $signed({3'd0, i_operand_b[14:10]})
                      - $signed(hfm_pkg::Bias);
        r_sig_a    <= {1'b1, i_operand_a[9:0]};
        r_sig_b    <= {1'b1, i_operand_b[9:0]};
    end

    // Stage two: the significand multiply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
        end else begin
            r_valid2 <= r_valid1;
        end
        r_sign2    <= r_sign1;
        r_special2 <= r_special1;
        r_exp2     <= r_exp1;
        r_prod     <= r_sig_a * r_sig_b;
    end

    hfm_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_valid2),
        .i_sign    (r_sign2),
        .i_special (r_special2),
        .i_exp     (r_exp2),
        .i_prod    (r_prod),
        .o_valid   (o_done),
        .o_product (o_product)
    );

    // A normal product always has its top or next bit set.
    `HFM_ASSERT_IMP(a_prod_norm, i_clk, i_rst_n,
        r_valid2 && r_special2 == hfm_pkg::SP_NONE, r_prod[21] || r_prod[20], "product not normal")
    // Items pass from stage one to stage two without loss.
    `HFM_ASSERT_NEXT(a_valid_flow, i_clk, i_rst_n, r_valid1, r_valid2, "item lost in pipeline")
    // A NaN on operand A with start high is flagged as NaN in stage one.
    `HFM_ASSERT_NEXT(a_nan_pass, i_clk, i_rst_n,
        start && ((i_operand_a[14:10] == 5'd31 && i_operand_a[9:0] != 10'd0)),
        r_special1 == hfm_pkg::SP_NAN, "NaN operand not flagged")

endmodule
